// ===== rtl/efr_pkg.sv =====
package efr_pkg;

  // input operation codes
  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_BYTE  = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  // line actions
  localparam logic [1:0] ACT_NONE = 2'd0;
  localparam logic [1:0] ACT_POLL = 2'd1;
  localparam logic [1:0] ACT_ACK  = 2'd2;
  localparam logic [1:0] ACT_NAK  = 2'd3;

  // session end codes
  localparam logic [1:0] END_GOOD    = 2'd0;
  localparam logic [1:0] END_ACK     = 2'd1;
  localparam logic [1:0] END_TIMEOUT = 2'd2;
  localparam logic [1:0] END_CKSUM   = 2'd3;

  // register indexes
  localparam logic [1:0] REG_START_BYTE    = 2'd0;
  localparam logic [1:0] REG_OWN_ADDRESS   = 2'd1;
  localparam logic [1:0] REG_MAX_RETRIES   = 2'd2;
  localparam logic [1:0] REG_TIMEOUT_LIMIT = 2'd3;

  // register reset values
  localparam logic [7:0] RST_START_BYTE    = 8'h7F;
  localparam logic [7:0] RST_OWN_ADDRESS   = 8'hFE;
  localparam logic [2:0] RST_MAX_RETRIES   = 3'd2;
  localparam logic [3:0] RST_TIMEOUT_LIMIT = 4'd3;

  // line bytes
  localparam logic [7:0] ESC_BYTE  = 8'h8E;
  localparam logic [7:0] ACK_BYTE  = 8'h8D;
  localparam logic [7:0] ESC_CODE1 = 8'h01;
  localparam logic [7:0] ESC_CODE2 = 8'h02;
  localparam logic [7:0] ESC_VAL1  = 8'h7F;
  localparam logic [7:0] ESC_VAL2  = 8'h8F;

  localparam logic [3:0] TMO_MAX = 4'hF;

  localparam int QUEUE_DEPTH = 2;

  localparam int CNT_W = 17;

  typedef enum logic [1:0] {
    K_START = 2'd0,
    K_BYTE  = 2'd1,
    K_TICK  = 2'd2,
    K_NOP   = 2'd3
  } kind_t;

  // one classified word in the queue
  typedef struct packed {
    kind_t      kind;
    logic [7:0] arg;     // device id or raw byte
    logic [7:0] mapped;  // raw byte after escape mapping
    logic       is_esc;  // raw byte is the escape byte
  } qword_t;

  typedef struct packed {
    logic [1:0]       action;
    logic [7:0]       poll_target;
    logic             byte_valid;
    logic [7:0]       byte_value;
    logic [CNT_W-1:0] byte_index;
    logic             finished;
    logic [1:0]       outcome;
    logic [CNT_W-1:0] frame_length;
  } result_t;

  typedef struct packed {
    logic [7:0] start_byte;
    logic [7:0] own_address;
    logic [2:0] max_retries;
    logic [3:0] timeout_limit;
  } cfg_t;

  typedef enum logic [7:0] {
    PH_HUNT    = 8'b0000_0001,
    PH_DEST    = 8'b0000_0010,
    PH_SRC     = 8'b0000_0100,
    PH_CMD     = 8'b0000_1000,
    PH_LEN_HI  = 8'b0001_0000,
    PH_LEN_LO  = 8'b0010_0000,
    PH_PAYLOAD = 8'b0100_0000,
    PH_CKSUM   = 8'b1000_0000
  } phase_t;

endpackage

// ===== rtl/efr_front.sv =====
module efr_front (
  input  logic              in_valid,
  input  logic [1:0]        in_operation,
  input  logic [7:0]        in_data_byte,
  input  logic [7:0]        in_device_id,
  input  logic              q_full,
  output logic              in_stall,
  output logic              q_push,
  output efr_pkg::qword_t   q_wdata
);
  import efr_pkg::*;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_wdata        = '0;
    q_wdata.is_esc = (in_data_byte == ESC_BYTE);
    if (in_data_byte == ESC_CODE1) begin
      q_wdata.mapped = ESC_VAL1;
    end else if (in_data_byte == ESC_CODE2) begin
      q_wdata.mapped = ESC_VAL2;
    end else begin
      q_wdata.mapped = in_data_byte;
    end
    case (in_operation)
      OP_START: begin
        q_wdata.kind = K_START;
        q_wdata.arg  = in_device_id;
      end
      OP_BYTE: begin
        q_wdata.kind = K_BYTE;
        q_wdata.arg  = in_data_byte;
      end
      OP_TICK: begin
        q_wdata.kind = K_TICK;
        q_wdata.arg  = in_data_byte;
      end
      default: begin
        q_wdata.kind = K_NOP;
        q_wdata.arg  = in_data_byte;
      end
    endcase
  end

endmodule

// ===== rtl/efr_queue.sv =====
module efr_queue #(
  parameter int DEPTH = efr_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  efr_pkg::qword_t   wdata,
  input  logic              pop,
  output logic              full,
  output logic              not_empty,
  output efr_pkg::qword_t   rdata
);
  import efr_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST  = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULLC = CW'(DEPTH);

  qword_t          mem_r [DEPTH];
  logic [PW-1:0]   wptr_r, wptr_nxt;
  logic [PW-1:0]   rptr_r, rptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;

  assign full      = (count_r == FULLC);
  assign not_empty = (count_r != '0);
  assign rdata     = mem_r[rptr_r];

  always_comb begin
    wptr_nxt  = wptr_r;
    rptr_nxt  = rptr_r;
    count_nxt = count_r;
    if (push) begin
      wptr_nxt = (wptr_r == LAST) ? '0 : wptr_r + 1'b1;
    end
    if (pop) begin
      rptr_nxt = (rptr_r == LAST) ? '0 : rptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= wdata;
    end
  end

endmodule

// ===== rtl/efr_back.sv =====
module efr_back (
  input  logic              clk,
  input  logic              rst_n,
  input  efr_pkg::cfg_t     cfg,
  input  logic              q_not_empty,
  input  efr_pkg::qword_t   q_rdata,
  output logic              q_pop,
  input  logic              out_stall,
  output logic              out_valid,
  output efr_pkg::result_t  out_res
);
  import efr_pkg::*;

  logic             active_r, active_nxt;
  phase_t           phase_r, phase_nxt;
  logic             esc_r, esc_nxt;
  logic [7:0]       sum_r, sum_nxt;
  logic [15:0]      remain_r, remain_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [2:0]       retry_r, retry_nxt;
  logic [3:0]       tmo_r, tmo_nxt;
  logic             out_valid_r, out_valid_nxt;
  result_t          res_r, res_nxt;

  logic [7:0]       b;
  logic             skip;
  logic [7:0]       sum_add;
  logic [15:0]      len_full;
  logic [15:0]      remain_dec;

  assign q_pop     = q_not_empty && (!out_valid_r || !out_stall);
  assign out_valid = out_valid_r;
  assign out_res   = res_r;

  assign sum_add    = sum_r + b;
  assign len_full   = {remain_r[15:8], b};
  assign remain_dec = remain_r - 16'd1;

  always_comb begin
    b = q_rdata.arg;
    if (esc_r) begin
      b = q_rdata.mapped;
    end
  end

  always_comb begin
    active_nxt = active_r;
    phase_nxt  = phase_r;
    esc_nxt    = esc_r;
    sum_nxt    = sum_r;
    remain_nxt = remain_r;
    cnt_nxt    = cnt_r;
    retry_nxt  = retry_r;
    tmo_nxt    = tmo_r;
    res_nxt    = '0;
    skip       = 1'b0;

    if (q_pop) begin
      case (q_rdata.kind)
        K_START: begin
          active_nxt          = 1'b1;
          phase_nxt           = PH_HUNT;
          esc_nxt             = 1'b0;
          sum_nxt             = '0;
          remain_nxt          = '0;
          cnt_nxt             = '0;
          retry_nxt           = '0;
          tmo_nxt             = '0;
          res_nxt.action      = ACT_POLL;
          res_nxt.poll_target = q_rdata.arg;
        end
        K_BYTE: begin
          if (active_r) begin
            tmo_nxt = '0;
            if (esc_r) begin
              esc_nxt = 1'b0;
            end else if (phase_r != PH_HUNT && q_rdata.is_esc) begin
              esc_nxt = 1'b1;
              skip    = 1'b1;
            end
            if (!skip) begin
              // every phase but an unmatched hunt stores the byte
              res_nxt.byte_value = b;
              res_nxt.byte_index = cnt_r;
              cnt_nxt            = cnt_r + 1'b1;
              res_nxt.byte_valid = 1'b1;
              sum_nxt            = sum_add;
              case (phase_r)
                PH_HUNT: begin
                  if (b == cfg.start_byte) begin
                    res_nxt.byte_index = '0;
                    cnt_nxt            = CNT_W'(1);
                    sum_nxt            = b;
                    phase_nxt          = PH_DEST;
                  end else begin
                    res_nxt.byte_valid = 1'b0;
                    res_nxt.byte_value = '0;
                    res_nxt.byte_index = '0;
                    cnt_nxt            = cnt_r;
                    sum_nxt            = sum_r;
                    if (b == ACK_BYTE) begin
                      res_nxt.finished = 1'b1;
                      res_nxt.outcome  = END_ACK;
                      active_nxt       = 1'b0;
                      esc_nxt          = 1'b0;
                    end
                  end
                end
                PH_DEST: begin
                  phase_nxt = (b == cfg.own_address) ? PH_SRC : PH_HUNT;
                end
                PH_SRC: begin
                  phase_nxt = PH_CMD;
                end
                PH_CMD: begin
                  phase_nxt = PH_LEN_HI;
                end
                PH_LEN_HI: begin
                  remain_nxt = {b, 8'h00};
                  phase_nxt  = PH_LEN_LO;
                end
                PH_LEN_LO: begin
                  remain_nxt = len_full;
                  phase_nxt  = (len_full == '0) ? PH_CKSUM : PH_PAYLOAD;
                end
                PH_PAYLOAD: begin
                  remain_nxt = remain_dec;
                  if (remain_dec == '0) begin
                    phase_nxt = PH_CKSUM;
                  end
                end
                default: begin
                  // checksum: good when the byte sum closes to zero
                  sum_nxt   = sum_r;
                  phase_nxt = PH_HUNT;
                  if (sum_add == '0) begin
                    res_nxt.action       = ACT_ACK;
                    res_nxt.frame_length = cnt_r + 1'b1;
                    res_nxt.finished     = 1'b1;
                    res_nxt.outcome      = END_GOOD;
                    active_nxt           = 1'b0;
                    esc_nxt              = 1'b0;
                  end else if (retry_r >= cfg.max_retries) begin
                    res_nxt.finished = 1'b1;
                    res_nxt.outcome  = END_CKSUM;
                    active_nxt       = 1'b0;
                    esc_nxt          = 1'b0;
                  end else begin
                    retry_nxt      = retry_r + 1'b1;
                    res_nxt.action = ACT_NAK;
                  end
                end
              endcase
            end
          end
        end
        K_TICK: begin
          if (active_r) begin
            tmo_nxt = (tmo_r != TMO_MAX) ? tmo_r + 1'b1 : tmo_r;
            if (tmo_nxt >= cfg.timeout_limit) begin
              res_nxt.finished = 1'b1;
              res_nxt.outcome  = END_TIMEOUT;
              active_nxt       = 1'b0;
              phase_nxt        = PH_HUNT;
              esc_nxt          = 1'b0;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    if (q_pop) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      phase_r     <= PH_HUNT;
      esc_r       <= 1'b0;
      sum_r       <= '0;
      remain_r    <= '0;
      cnt_r       <= '0;
      retry_r     <= '0;
      tmo_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      active_r    <= active_nxt;
      phase_r     <= phase_nxt;
      esc_r       <= esc_nxt;
      sum_r       <= sum_nxt;
      remain_r    <= remain_nxt;
      cnt_r       <= cnt_nxt;
      retry_r     <= retry_nxt;
      tmo_r       <= tmo_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      res_r <= res_nxt;
    end
  end

endmodule

// ===== rtl/escaped_frame_receiver.sv =====
// Channel | Direction | Handshake            | Word
// in_     | input     | in_valid / in_stall  | operation, data_byte, device_id
// out_    | output    | out_valid / out_stall| action ... frame_length (8 fields)
// APB     | input     | psel/penable/pready  | 4 registers at byte address 4*i
//
// One word per cycle sustained while out_stall stays low; an accepted word passes
// the queue write, then the registered parser step, before its result leaves.
// in_stall rises when the queue is full (two words at the default depth); with
// words arriving every cycle a stalled result is enough to fill it.
// rst_n is synchronous: clears session, queue and output valid, loads
// register defaults. Configuration writes belong in idle periods only.
module escaped_frame_receiver #(
  parameter int QDEPTH = efr_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_operation,
  input  logic [7:0]  in_data_byte,
  input  logic [7:0]  in_device_id,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_action,
  output logic [7:0]  out_poll_target,
  output logic        out_byte_valid,
  output logic [7:0]  out_byte_value,
  output logic [16:0] out_byte_index,
  output logic        out_finished,
  output logic [1:0]  out_outcome,
  output logic [16:0] out_frame_length,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import efr_pkg::*;

  cfg_t       cfg_r, cfg_nxt;
  logic [1:0] cfg_idx;
  logic       cfg_wr;

  qword_t     q_wdata, q_rdata;
  logic       q_push, q_pop, q_full, q_not_empty;
  result_t    res;

  // ---------------- configuration port ----------------
  assign pready  = 1'b1;
  assign cfg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr) begin
      case (cfg_idx)
        REG_START_BYTE:    cfg_nxt.start_byte    = pwdata[7:0];
        REG_OWN_ADDRESS:   cfg_nxt.own_address   = pwdata[7:0];
        REG_MAX_RETRIES:   cfg_nxt.max_retries   = pwdata[2:0];
        REG_TIMEOUT_LIMIT: cfg_nxt.timeout_limit = pwdata[3:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_START_BYTE:    prdata = {24'd0, cfg_r.start_byte};
      REG_OWN_ADDRESS:   prdata = {24'd0, cfg_r.own_address};
      REG_MAX_RETRIES:   prdata = {29'd0, cfg_r.max_retries};
      REG_TIMEOUT_LIMIT: prdata = {28'd0, cfg_r.timeout_limit};
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_byte    <= RST_START_BYTE;
      cfg_r.own_address   <= RST_OWN_ADDRESS;
      cfg_r.max_retries   <= RST_MAX_RETRIES;
      cfg_r.timeout_limit <= RST_TIMEOUT_LIMIT;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // ---------------- front: accept and classify ----------------
  efr_front u_front (
    .in_valid     (in_valid),
    .in_operation (in_operation),
    .in_data_byte (in_data_byte),
    .in_device_id (in_device_id),
    .q_full       (q_full),
    .in_stall     (in_stall),
    .q_push       (q_push),
    .q_wdata      (q_wdata)
  );

  // ---------------- decoupling queue ----------------
  efr_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .wdata     (q_wdata),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .rdata     (q_rdata)
  );

  // ---------------- back: frame parser and result register ----------------
  efr_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .q_not_empty (q_not_empty),
    .q_rdata     (q_rdata),
    .q_pop       (q_pop),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .out_res     (res)
  );

  assign out_action       = res.action;
  assign out_poll_target  = res.poll_target;
  assign out_byte_valid   = res.byte_valid;
  assign out_byte_value   = res.byte_value;
  assign out_byte_index   = res.byte_index;
  assign out_finished     = res.finished;
  assign out_outcome      = res.outcome;
  assign out_frame_length = res.frame_length;

endmodule
